// ===== src/crvs_pkg.sv =====
// Shared constants, types and helpers for the CSR row vector segmenter.
`default_nettype none

package crvs_pkg;

    // Lane count of one vector. Block and lane arithmetic uses shifts and masks,
    // so LANES is a power of two.
    localparam int unsigned LANES     = 8;
    localparam int unsigned LANE_BITS = $clog2(LANES);

    localparam int unsigned OFS_W   = 32;
    localparam int unsigned COUNT_W = 30;
    localparam int unsigned MASK_W  = 8;
    localparam int unsigned ROW_W   = 32;
    localparam int unsigned BLOCK_W = 29;
    localparam int unsigned RECN_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [LANE_BITS-1:0] lane_fill;
        logic [LANES-1:0]     boundary_mask;
        logic [ROW_W-1:0]     group_first_row;
        logic [BLOCK_W-1:0]   group_first_block;
        logic [ROW_W-1:0]     row_counter;
        logic [RECN_W-1:0]    record_counter;
    } t_state;

    localparam t_state ST_RESET = '{
        lane_fill:         '0,
        boundary_mask:     LANES'(1),
        group_first_row:   '0,
        group_first_block: '0,
        row_counter:       '0,
        record_counter:    '0
    };

    typedef struct packed {
        logic [COUNT_W-1:0] group_count;
        logic [MASK_W-1:0]  row_mask;
        logic [ROW_W-1:0]   first_row;
        logic [BLOCK_W-1:0] first_block;
        logic [RECN_W-1:0]  record_number;
        logic               last_of_step;
    } t_rec;

    typedef struct packed {
        logic [1:0] n_recs;
        t_rec       rec0;
        t_rec       rec1;
        t_state     nxt;
    } t_step;

    // Lane mask to the 8-bit output field: low bits kept, zero filled.
    function automatic logic [MASK_W-1:0] to_row_mask(input logic [LANES-1:0] bm);
        logic [LANES+MASK_W-1:0] ext;
        ext = (LANES + MASK_W)'(bm);
        return ext[MASK_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/csr_row_vector_segmenter.sv =====
// Top level of the CSR row vector segmenter: input register, step, record buffer.
`default_nettype none

// Channel  Dir  Fields (tdata low bit up)                         tlast
// s_*      in   row_start[31:0], row_end[63:32]                   last_row
// m_*      out  group_count[29:0], row_mask[37:30],               last_of_step
//               first_row[69:38], first_block[98:70],
//               record_number[130:99], zero pad[135:131]
//
// Flow: a row transfer is registered, stepped against the open vector state
// and its records are registered into a two-entry record buffer. A row
// giving two records fills both slots, and the single master channel moves
// one record per transfer.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the
// vector state; no clearing pass. A stalled master holds the buffer; a row
// that yields records waits in the input register until the buffer drains,
// stalling the slave side, while rows that yield none still step through.

module csr_row_vector_segmenter
    import crvs_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [63:0]  i_s_tdata,   // row_start, row_end
    input  wire logic         i_s_tlast,   // last_row

    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [135:0]      o_m_tdata,   // group_count, row_mask, first_row,
                                           // first_block, record_number, pad
    output logic              o_m_tlast    // last_of_step
);

    // input register
    logic             r_in_v, n_in_v;
    logic [OFS_W-1:0] r_in_rs, n_in_rs;
    logic [OFS_W-1:0] r_in_re, n_in_re;
    logic             r_in_last, n_in_last;

    // open vector state
    t_state           r_st, n_st;

    // record buffer: slot0 is presented, slot1 waits behind it
    logic [1:0]       r_cnt, n_cnt;
    t_rec             r_slot0, n_slot0;
    t_rec             r_slot1, n_slot1;

    t_step            step;
    logic             take;
    logic             fire;
    logic             s_xfer;
    logic [1:0]       cnt_left;

    crvs_step u_step (
        .i_row_start (r_in_rs),
        .i_row_end   (r_in_re),
        .i_last_row  (r_in_last),
        .i_st        (r_st),
        .o_step      (step)
    );

    always_comb begin
        take     = (r_cnt != 2'd0) && i_m_tready;
        cnt_left = r_cnt - {1'b0, take};
        // a row steps once the buffer will be empty, or right away if it
        // produces no records
        fire       = r_in_v && ((step.n_recs == 2'd0) || (cnt_left == 2'd0));
        o_s_tready = !r_in_v || fire;
        s_xfer     = i_s_tvalid && o_s_tready;

        n_in_v    = s_xfer || (r_in_v && !fire);
        n_in_rs   = s_xfer ? i_s_tdata[31:0]  : r_in_rs;
        n_in_re   = s_xfer ? i_s_tdata[63:32] : r_in_re;
        n_in_last = s_xfer ? i_s_tlast        : r_in_last;

        n_st    = fire ? step.nxt : r_st;
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (fire && (step.n_recs != 2'd0)) begin
            n_slot0 = step.rec0;
            n_slot1 = step.rec1;
            n_cnt   = step.n_recs;
        end else if (take) begin
            n_slot0 = r_slot1;
            n_cnt   = cnt_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_cnt  <= 2'd0;
            r_st   <= ST_RESET;
        end else begin
            r_in_v <= n_in_v;
            r_cnt  <= n_cnt;
            r_st   <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_rs   <= n_in_rs;
        r_in_re   <= n_in_re;
        r_in_last <= n_in_last;
        r_slot0   <= n_slot0;
        r_slot1   <= n_slot1;
    end

    assign o_m_tvalid = r_cnt != 2'd0;
    assign o_m_tdata  = {5'b0, r_slot0.record_number, r_slot0.first_block,
                         r_slot0.first_row, r_slot0.row_mask, r_slot0.group_count};
    assign o_m_tlast  = r_slot0.last_of_step;

endmodule

`default_nettype wire

// ===== src/crvs_step.sv =====
// Combinational step logic: one row against the open vector state.
`default_nettype none

module crvs_step
    import crvs_pkg::*;
(
    input  wire logic [OFS_W-1:0] i_row_start,
    input  wire logic [OFS_W-1:0] i_row_end,
    input  wire logic             i_last_row,
    input  wire t_state           i_st,
    output t_step                 o_step
);

    logic [OFS_W-1:0]     cur;
    logic [OFS_W:0]       sum;
    logic                 wrap;
    logic                 fill_nz;
    logic [LANE_BITS:0]   top;
    logic [OFS_W-1:0]     body;
    logic [OFS_W-1:0]     runs;
    logic                 runs_nz;
    logic [LANE_BITS-1:0] rem;
    logic                 rem_nz;
    logic [BLOCK_W-1:0]   run_block;
    logic [COUNT_W-1:0]   run_count;
    logic [LANE_BITS-1:0] fill_new;
    t_rec                 mixed;
    t_rec                 run;
    t_state               nxt;
    logic [1:0]           n_recs;

    always_comb begin
        // reversed row counts as empty
        cur       = (i_row_end >= i_row_start) ? (i_row_end - i_row_start) : '0;
        sum       = {1'b0, cur} + (OFS_W + 1)'(i_st.lane_fill);
        wrap      = sum >= (OFS_W + 1)'(LANES);
        fill_nz   = i_st.lane_fill != '0;
        top       = fill_nz ? ((LANE_BITS + 1)'(LANES) - (LANE_BITS + 1)'(i_st.lane_fill))
                            : '0;
        body      = cur - OFS_W'(top);
        runs      = body >> LANE_BITS;
        runs_nz   = runs != '0;
        rem       = body[LANE_BITS-1:0];
        rem_nz    = rem != '0;
        run_block = BLOCK_W'(({1'b0, i_row_start} + (OFS_W + 1)'(top)) >> LANE_BITS);
        run_count = (runs > OFS_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(runs);
        fill_new  = i_st.lane_fill + cur[LANE_BITS-1:0];

        mixed.group_count   = COUNT_W'(1);
        mixed.row_mask      = to_row_mask(i_st.boundary_mask);
        mixed.first_row     = i_st.group_first_row;
        mixed.first_block   = i_st.group_first_block;
        mixed.record_number = i_st.record_counter;
        mixed.last_of_step  = !runs_nz;

        run.group_count   = run_count;
        run.row_mask      = MASK_W'(1);
        run.first_row     = i_st.row_counter;
        run.first_block   = run_block;
        run.record_number = fill_nz ? (i_st.record_counter + RECN_W'(1))
                                    : i_st.record_counter;
        run.last_of_step  = 1'b1;

        nxt             = i_st;
        nxt.row_counter = i_st.row_counter + ROW_W'(1);
        if (wrap) begin
            n_recs                = {1'b0, fill_nz} + {1'b0, runs_nz};
            nxt.lane_fill         = rem;
            nxt.boundary_mask     = LANES'(1) | (rem_nz ? (LANES'(1) << rem) : '0);
            nxt.group_first_row   = rem_nz ? i_st.row_counter
                                           : (i_st.row_counter + ROW_W'(1));
            nxt.group_first_block = rem_nz ? BLOCK_W'((i_row_end - OFS_W'(rem)) >> LANE_BITS)
                                           : BLOCK_W'(i_row_end >> LANE_BITS);
        end else begin
            n_recs            = 2'd0;
            nxt.lane_fill     = fill_new;
            nxt.boundary_mask = i_st.boundary_mask | (LANES'(1) << fill_new);
        end
        nxt.record_counter = i_st.record_counter + RECN_W'(n_recs);
        if (i_last_row) begin
            nxt = ST_RESET;
        end

        o_step.n_recs = n_recs;
        o_step.rec0   = fill_nz ? mixed : run;
        o_step.rec1   = run;
        o_step.nxt    = nxt;
    end

endmodule

`default_nettype wire
